// ----- sv/glyph_text_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// glyph_text_tokenizer assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_TOKENIZER_MACROS_SVH
`define GLYPH_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication
`define GTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/gtt_pkg.sv -----
// ----------------------------------------------------------------------------
// gtt_pkg
// Shared types, token codes and fraction scaling tables of the glyph text
// tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtt_pkg;

	localparam int FRAC_DIGITS_MAX = 4;
	localparam int RECIP_SHIFT     = 30;
	localparam longint ONE_SCALED  = 64'd1 << RECIP_SHIFT;

	localparam logic [3:0] TK_ERROR  = 4'd0;
	localparam logic [3:0] TK_GCODE  = 4'd1;
	localparam logic [3:0] TK_EQUAL  = 4'd2;
	localparam logic [3:0] TK_LBRACE = 4'd3;
	localparam logic [3:0] TK_RBRACE = 4'd4;
	localparam logic [3:0] TK_LPAREN = 4'd5;
	localparam logic [3:0] TK_RPAREN = 4'd6;
	localparam logic [3:0] TK_COLON  = 4'd7;
	localparam logic [3:0] TK_COMMA  = 4'd8;
	localparam logic [3:0] TK_GT     = 4'd9;
	localparam logic [3:0] TK_NUMBER = 4'd10;
	localparam logic [3:0] TK_END    = 4'd11;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} char_item_t;

	typedef struct packed {
		logic [3:0]         token_kind;
		logic [31:0]        code_value;
		logic signed [31:0] number_value;
		logic               last;
	} tok_item_t;

	typedef struct packed {
		logic capture;
		logic mul_en;
		logic qp_en;
		logic fix_en;
		logic load_out;
		logic out_second;
	} gtt_cmd_t;

	typedef struct packed {
		logic dec_tok;
		logic dec_num;
		logic tok2_pend;
	} gtt_stat_t;

	function automatic logic [13:0] pow10(input logic [2:0] cnt);
		case (cnt)
			3'd0:    pow10 = 14'd1;
			3'd1:    pow10 = 14'd10;
			3'd2:    pow10 = 14'd100;
			3'd3:    pow10 = 14'd1000;
			3'd4:    pow10 = 14'd10000;
			default: pow10 = 14'd1;
		endcase
	endfunction

	// floor(2^RECIP_SHIFT / 10^cnt)
	function automatic logic [30:0] recip10(input logic [2:0] cnt);
		case (cnt)
			3'd0:    recip10 = 31'(ONE_SCALED);
			3'd1:    recip10 = 31'(ONE_SCALED / 10);
			3'd2:    recip10 = 31'(ONE_SCALED / 100);
			3'd3:    recip10 = 31'(ONE_SCALED / 1000);
			3'd4:    recip10 = 31'(ONE_SCALED / 10000);
			default: recip10 = 31'(ONE_SCALED);
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- sv/gtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtt_ctrl
// Sequencer of the tokenizer: input capture, fraction scaling steps and
// transfer of up to two pending tokens into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtt_ctrl
	import gtt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      char_valid,
	output logic           char_ready,
	output logic           tok_valid,
	input  wire logic      tok_ready,
	input  wire gtt_stat_t stat,
	output gtt_cmd_t       cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL   = 6'b000010,
		ST_QP    = 6'b000100,
		ST_FIX   = 6'b001000,
		ST_MOVE1 = 6'b010000,
		ST_MOVE2 = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || tok_ready;
	assign char_ready = (state_q == ST_IDLE);
	assign tok_valid  = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.capture    = char_valid && char_ready;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					if (stat.dec_num) begin
						state_d = ST_MUL;
					end else if (stat.dec_tok) begin
						state_d = ST_MOVE1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_QP;
			end
			ST_QP: begin
				cmd.qp_en = 1'b1;
				state_d   = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix_en = 1'b1;
				state_d    = ST_MOVE1;
			end
			ST_MOVE1: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = stat.tok2_pend ? ST_MOVE2 : ST_IDLE;
				end
			end
			ST_MOVE2: begin
				if (out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_second = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (tok_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/gtt_dp.sv -----
// ----------------------------------------------------------------------------
// gtt_dp
// Lexer state, byte decode, pending token store, Q16.16 fraction scaler
// (reciprocal multiply with one correction step) and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtt_dp
	import gtt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire char_item_t char_data,
	input  wire gtt_cmd_t   cmd,
	output gtt_stat_t       stat,
	output tok_item_t       tok_data
);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_AT   = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_NUM  = 2'd3
	} mode_t;

	mode_t       mode_q, mode_d;
	logic        neg_q, neg_d;
	logic [14:0] whole_q, whole_d;
	logic [13:0] frac_q, frac_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        infrac_q, infrac_d;
	logic [31:0] hex_q, hex_d;

	logic [7:0]  c;
	logic        is_dig, is_hex, run_idle;
	logic [3:0]  dig_val, hex_val;
	logic [18:0] whole_ext;
	logic [17:0] frac_ext;
	logic        t1_valid, t2_valid, idle_valid;
	logic [3:0]  t1_kind, t2_kind, idle_kind;

	// pending tokens and number operands
	logic [3:0]  tok1_kind_q, tok2_kind_q;
	logic [31:0] tok1_code_q;
	logic        tok2_valid_q;
	logic        sn_neg_q;
	logic [14:0] sn_whole_q;
	logic [13:0] sn_frac_q;
	logic [2:0]  sn_cnt_q;

	// scaler
	logic [29:0] numer;
	logic [60:0] prod;
	logic [16:0] qest_q;
	logic [30:0] qp_q;
	logic [30:0] rem;
	logic [16:0] qfix;
	logic [31:0] mag;
	logic [31:0] num_val_q;
	tok_item_t   out_q;

	assign c         = char_data.char_byte;
	assign is_dig    = (c inside {[CH_ZERO:CH_NINE]});
	assign is_hex    = is_dig || (c inside {[CH_UPPER_A:CH_UPPER_F]});
	assign dig_val   = c[3:0];
	assign hex_val   = is_dig ? c[3:0] : c[3:0] + 4'd9;
	assign whole_ext = 19'(whole_q) * 19'd10 + 19'(dig_val);
	assign frac_ext  = 18'(frac_q) * 18'd10 + 18'(dig_val);

	always_comb begin
		mode_d     = mode_q;
		neg_d      = neg_q;
		whole_d    = whole_q;
		frac_d     = frac_q;
		cnt_d      = cnt_q;
		infrac_d   = infrac_q;
		hex_d      = hex_q;
		t1_valid   = 1'b0;
		t1_kind    = TK_ERROR;
		t2_valid   = 1'b0;
		t2_kind    = TK_ERROR;
		run_idle   = 1'b0;
		idle_valid = 1'b0;
		idle_kind  = TK_ERROR;

		if (char_data.end_of_input) begin
			case (mode_q)
				MODE_AT: begin
					t1_valid = 1'b1;
					t1_kind  = TK_ERROR;
				end
				MODE_HEX: begin
					t1_valid = 1'b1;
					t1_kind  = TK_GCODE;
				end
				MODE_NUM: begin
					t1_valid = 1'b1;
					t1_kind  = TK_NUMBER;
				end
				default: begin
					t1_valid = 1'b0;
				end
			endcase
			if (t1_valid) begin
				t2_valid = 1'b1;
				t2_kind  = TK_END;
			end else begin
				t1_valid = 1'b1;
				t1_kind  = TK_END;
			end
			mode_d   = MODE_IDLE;
			neg_d    = 1'b0;
			whole_d  = '0;
			frac_d   = '0;
			cnt_d    = '0;
			infrac_d = 1'b0;
			hex_d    = '0;
		end else begin
			case (mode_q)
				MODE_AT: begin
					if (is_hex) begin
						hex_d  = {28'd0, hex_val};
						mode_d = MODE_HEX;
					end else begin
						t1_valid = 1'b1;
						t1_kind  = TK_ERROR;
						mode_d   = MODE_IDLE;
					end
				end
				MODE_HEX: begin
					if (is_hex) begin
						hex_d = {hex_q[27:0], hex_val};
					end else begin
						t1_valid = 1'b1;
						t1_kind  = TK_GCODE;
						mode_d   = MODE_IDLE;
						run_idle = 1'b1;
					end
				end
				MODE_NUM: begin
					if (c == CH_POINT) begin
						if (infrac_q) begin
							t1_valid = 1'b1;
							t1_kind  = TK_ERROR;
							mode_d   = MODE_IDLE;
						end else begin
							infrac_d = 1'b1;
						end
					end else if (is_dig) begin
						if (!infrac_q) begin
							whole_d = (whole_ext > 19'd32767) ? 15'h7FFF : whole_ext[14:0];
						end else if (cnt_q < 3'(FRAC_DIGITS_MAX)) begin
							frac_d = frac_ext[13:0];
							cnt_d  = cnt_q + 3'd1;
						end
					end else begin
						t1_valid = 1'b1;
						t1_kind  = TK_NUMBER;
						mode_d   = MODE_IDLE;
						run_idle = 1'b1;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase

			if (run_idle) begin
				idle_valid = 1'b1;
				case (c)
					CH_SPACE, CH_TAB, CH_NL: begin
						idle_valid = 1'b0;
					end
					CH_AT: begin
						idle_valid = 1'b0;
						mode_d     = MODE_AT;
						hex_d      = '0;
					end
					CH_EQUAL:  idle_kind = TK_EQUAL;
					CH_LBRACE: idle_kind = TK_LBRACE;
					CH_RBRACE: idle_kind = TK_RBRACE;
					CH_LPAREN: idle_kind = TK_LPAREN;
					CH_RPAREN: idle_kind = TK_RPAREN;
					CH_COLON:  idle_kind = TK_COLON;
					CH_COMMA:  idle_kind = TK_COMMA;
					CH_GT:     idle_kind = TK_GT;
					CH_PLUS, CH_MINUS, CH_POINT: begin
						idle_valid = 1'b0;
						mode_d     = MODE_NUM;
						neg_d      = (c == CH_MINUS);
						whole_d    = '0;
						frac_d     = '0;
						cnt_d      = '0;
						infrac_d   = (c == CH_POINT);
					end
					default: begin
						if (is_dig) begin
							idle_valid = 1'b0;
							mode_d     = MODE_NUM;
							neg_d      = 1'b0;
							whole_d    = 15'(dig_val);
							frac_d     = '0;
							cnt_d      = '0;
							infrac_d   = 1'b0;
						end else begin
							idle_kind = TK_ERROR;
						end
					end
				endcase
				if (idle_valid) begin
					if (t1_valid) begin
						t2_valid = 1'b1;
						t2_kind  = idle_kind;
					end else begin
						t1_valid = 1'b1;
						t1_kind  = idle_kind;
					end
				end
			end
		end
	end

	assign stat.dec_tok   = t1_valid;
	assign stat.dec_num   = t1_valid && (t1_kind == TK_NUMBER);
	assign stat.tok2_pend = tok2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			neg_q        <= 1'b0;
			whole_q      <= '0;
			frac_q       <= '0;
			cnt_q        <= '0;
			infrac_q     <= 1'b0;
			hex_q        <= '0;
			tok2_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			mode_q       <= mode_d;
			neg_q        <= neg_d;
			whole_q      <= whole_d;
			frac_q       <= frac_d;
			cnt_q        <= cnt_d;
			infrac_q     <= infrac_d;
			hex_q        <= hex_d;
			tok2_valid_q <= t2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tok1_kind_q <= t1_kind;
			tok2_kind_q <= t2_kind;
			tok1_code_q <= (t1_kind == TK_GCODE) ? hex_q : 32'd0;
			sn_neg_q    <= neg_q;
			sn_whole_q  <= whole_q;
			sn_frac_q   <= frac_q;
			sn_cnt_q    <= cnt_q;
		end
	end

	// fraction * 65536 + 10^n / 2, then divided by 10^n
	assign numer = {sn_frac_q, 16'd0} + 30'(pow10(sn_cnt_q) >> 1);
	assign prod  = 61'(numer) * 61'(recip10(sn_cnt_q));
	assign rem   = 31'(numer) - qp_q;
	assign qfix  = qest_q + 17'(rem >= 31'(pow10(sn_cnt_q)));
	assign mag   = {1'b0, sn_whole_q, 16'd0} + 32'(qfix);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			qest_q <= prod[RECIP_SHIFT +: 17];
		end
		if (cmd.qp_en) begin
			qp_q <= 31'(qest_q) * 31'(pow10(sn_cnt_q));
		end
		if (cmd.fix_en) begin
			if (sn_neg_q) begin
				num_val_q <= 32'd0 - mag;
			end else begin
				num_val_q <= mag[31] ? 32'h7FFF_FFFF : mag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.out_second) begin
				out_q.token_kind   <= tok2_kind_q;
				out_q.code_value   <= 32'd0;
				out_q.number_value <= 32'sd0;
				out_q.last         <= 1'b1;
			end else begin
				out_q.token_kind   <= tok1_kind_q;
				out_q.code_value   <= tok1_code_q;
				out_q.number_value <= (tok1_kind_q == TK_NUMBER) ? num_val_q : 32'd0;
				out_q.last         <= !tok2_valid_q;
			end
		end
	end

	assign tok_data = out_q;

endmodule

`default_nettype wire

// ----- sv/glyph_text_tokenizer.sv -----
// Throughput: one byte per cycle while bytes yield no token. A byte with tokens
// holds char_ready low until they are moved into the output register; a number
// first runs the scaling steps (reciprocal multiply, product, correction).
// The output register lets a new byte in while the last token waits for tok_ready.
// Reset: arst_n clears lexer and control state at once; no clearing pass.
// ----------------------------------------------------------------------------
// glyph_text_tokenizer
// Byte-serial lexer for glyph description text: punctuation, '@' hex glyph
// codes and decimal numbers as signed Q16.16, up to two tokens per beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "glyph_text_tokenizer_macros.svh"

module glyph_text_tokenizer
	import gtt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_ready,
	input  wire char_item_t char_data,
	output logic            tok_valid,
	input  wire logic       tok_ready,
	output tok_item_t       tok_data
);

	gtt_cmd_t  cmd;
	gtt_stat_t stat;

	gtt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	gtt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_data (char_data),
		.cmd       (cmd),
		.stat      (stat),
		.tok_data  (tok_data)
	);

	`GTT_ASSERT_NOW(a_end_is_last, tok_valid && tok_data.token_kind == TK_END, tok_data.last, "end token without last")
	`GTT_ASSERT_NOW(a_code_zero, tok_valid && tok_data.token_kind != TK_GCODE, tok_data.code_value == 32'd0, "code value on non-glyph token")
	`GTT_ASSERT_NOW(a_num_zero, tok_valid && tok_data.token_kind != TK_NUMBER, tok_data.number_value == 32'sd0, "number value on non-number token")
	`GTT_ASSERT_NEXT(a_end_busy, char_valid && char_ready && char_data.end_of_input, !char_ready, "end beat did not produce tokens")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - glyph_text_tokenizer testbench
// Streams text bytes and end markers into the lexer through a queue-fed
// driver, predicts every token from the bytes taken, and checks each token
// beat in order. Runs three idle profiles, with one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import gtt_pkg::*;

	typedef enum logic [1:0] {LX_IDLE, LX_AT, LX_HEX, LX_NUM} lex_mode_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	char_item_t char_data = '0;
	logic       tok_valid;
	logic       tok_ready = 1'b0;
	tok_item_t  tok_data;

	glyph_text_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	char_item_t text_chars[$];
	tok_item_t  due_tokens[$];
	int         mismatches = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       char_taken = 1'b0;
	logic       hold_req = 1'b0;
	logic       hold_seen = 1'b0;
	int         hold_left = 0;

	// lexer state of the predictor
	lex_mode_t   lx_mode = LX_IDLE;
	logic        num_neg = 1'b0;
	logic [14:0] num_whole = '0;
	logic [13:0] frac_val = '0;
	logic [2:0]  frac_cnt = '0;
	logic        in_frac = 1'b0;
	logic [31:0] hex_acc = '0;

	logic [7:0] directed_text [0:29] = '{
		CH_AT, "x", CH_EQUAL, CH_AT, "F", CH_LBRACE, CH_POINT, "5", CH_RBRACE,
		CH_MINUS, CH_LPAREN, "9", "9", "9", "9", "9", CH_POINT, "1", "2", "3",
		"4", "5", CH_POINT, CH_RPAREN, CH_COLON, CH_COMMA, CH_GT, 8'h00, 8'hFF,
		CH_PLUS
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	function automatic void push_token(input logic [3:0] kind, input logic [31:0] code,
			input logic [31:0] num);
		due_tokens.push_back(tok_item_t'{token_kind: kind, code_value: code,
			number_value: num, last: 1'b0});
	endfunction

	function automatic logic [31:0] q16_value();
		logic [63:0] scale;
		logic [63:0] frac;
		logic [63:0] mag;
		scale = 64'd1;
		for (int i = 0; i < frac_cnt; i++)
			scale = scale * 10;
		frac = (({50'd0, frac_val} << 16) + scale / 2) / scale;
		mag = ({49'd0, num_whole} << 16) + frac;
		if (num_neg) begin
			if (mag > 64'h8000_0000)
				mag = 64'h8000_0000;
			return 32'd0 - mag[31:0];
		end
		if (mag > 64'h7FFF_FFFF)
			mag = 64'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function automatic void begin_number(input logic neg, input logic point);
		lx_mode = LX_NUM;
		num_neg = neg;
		num_whole = '0;
		frac_val = '0;
		frac_cnt = '0;
		in_frac = point;
	endfunction

	function automatic void add_digit(input int d);
		int w;
		if (!in_frac) begin
			w = num_whole * 10 + d;
			num_whole = (w > 32767) ? 15'd32767 : 15'(w);
		end else if (frac_cnt < FRAC_DIGITS_MAX) begin
			frac_val = 14'(frac_val * 10 + d);
			frac_cnt = frac_cnt + 3'd1;
		end
	endfunction

	function automatic void idle_char(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_NL: ;
			CH_AT: begin
				lx_mode = LX_AT;
				hex_acc = '0;
			end
			CH_EQUAL:  push_token(TK_EQUAL, '0, '0);
			CH_LBRACE: push_token(TK_LBRACE, '0, '0);
			CH_RBRACE: push_token(TK_RBRACE, '0, '0);
			CH_LPAREN: push_token(TK_LPAREN, '0, '0);
			CH_RPAREN: push_token(TK_RPAREN, '0, '0);
			CH_COLON:  push_token(TK_COLON, '0, '0);
			CH_COMMA:  push_token(TK_COMMA, '0, '0);
			CH_GT:     push_token(TK_GT, '0, '0);
			CH_PLUS:   begin_number(1'b0, 1'b0);
			CH_MINUS:  begin_number(1'b1, 1'b0);
			CH_POINT:  begin_number(1'b0, 1'b1);
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					begin_number(1'b0, 1'b0);
					add_digit(int'(c - CH_ZERO));
				end else begin
					push_token(TK_ERROR, '0, '0);
				end
			end
		endcase
	endfunction

	function automatic void lex_char(input char_item_t it);
		int        before_n;
		int        d;
		tok_item_t tail;
		before_n = due_tokens.size();
		d = nibble_of(it.char_byte);
		if (it.end_of_input) begin
			case (lx_mode)
				LX_AT:  push_token(TK_ERROR, '0, '0);
				LX_HEX: push_token(TK_GCODE, hex_acc, '0);
				LX_NUM: push_token(TK_NUMBER, '0, q16_value());
				default: ;
			endcase
			push_token(TK_END, '0, '0);
			lx_mode = LX_IDLE;
			num_neg = 1'b0;
			num_whole = '0;
			frac_val = '0;
			frac_cnt = '0;
			in_frac = 1'b0;
			hex_acc = '0;
		end else begin
			case (lx_mode)
				LX_AT: begin
					if (d >= 0) begin
						hex_acc = 32'(d);
						lx_mode = LX_HEX;
					end else begin
						push_token(TK_ERROR, '0, '0);
						lx_mode = LX_IDLE;
					end
				end
				LX_HEX: begin
					if (d >= 0) begin
						hex_acc = {hex_acc[27:0], 4'(d)};
					end else begin
						push_token(TK_GCODE, hex_acc, '0);
						lx_mode = LX_IDLE;
						idle_char(it.char_byte);
					end
				end
				LX_NUM: begin
					if (it.char_byte == CH_POINT) begin
						if (in_frac) begin
							push_token(TK_ERROR, '0, '0);
							lx_mode = LX_IDLE;
						end else begin
							in_frac = 1'b1;
						end
					end else if (it.char_byte >= CH_ZERO && it.char_byte <= CH_NINE) begin
						add_digit(int'(it.char_byte - CH_ZERO));
					end else begin
						push_token(TK_NUMBER, '0, q16_value());
						lx_mode = LX_IDLE;
						idle_char(it.char_byte);
					end
				end
				default: idle_char(it.char_byte);
			endcase
		end
		if (due_tokens.size() > before_n) begin
			tail = due_tokens.pop_back();
			tail.last = 1'b1;
			due_tokens.push_back(tail);
		end
	endfunction

	function automatic void queue_char(input logic [7:0] c);
		text_chars.push_back(char_item_t'{char_byte: c, end_of_input: 1'b0});
	endfunction

	function automatic void queue_end();
		text_chars.push_back(char_item_t'{char_byte: 8'($urandom_range(255, 0)),
			end_of_input: 1'b1});
	endfunction

	function automatic void queue_digit(input bit nines);
		queue_char(CH_ZERO + (nines ? 8'd9 : 8'($urandom_range(9, 0))));
	endfunction

	function automatic void queue_glyph();
		int nib;
		queue_char(CH_AT);
		if ($urandom_range(9, 0) == 0) begin
			queue_char(8'($urandom_range(255, 0)));
		end else begin
			repeat ($urandom_range(10, 1)) begin
				nib = $urandom_range(15, 0);
				queue_char(nib < 10 ? CH_ZERO + 8'(nib) : CH_UPPER_A + 8'(nib - 10));
			end
		end
	endfunction

	function automatic void queue_number();
		int lead;
		bit nines;
		lead = $urandom_range(3, 0);
		nines = ($urandom_range(7, 0) == 0);
		case (lead)
			1: queue_char(CH_PLUS);
			2: queue_char(CH_MINUS);
			3: queue_char(CH_POINT);
			default: ;
		endcase
		repeat ($urandom_range(6, (lead == 0) ? 1 : 0))
			queue_digit(nines);
		if (lead != 3 && $urandom_range(1, 0) == 1) begin
			queue_char(CH_POINT);
			repeat ($urandom_range(6, 0))
				queue_digit(nines);
		end
		if ($urandom_range(11, 0) == 0)
			queue_char(CH_POINT);
	endfunction

	function automatic void queue_random_text(input int count);
		logic [7:0] marks [0:7];
		logic [7:0] blanks [0:2];
		int target;
		int pick;
		marks = '{CH_EQUAL, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_COLON,
			CH_COMMA, CH_GT};
		blanks = '{CH_SPACE, CH_TAB, CH_NL};
		target = text_chars.size() + count;
		while (text_chars.size() < target) begin
			pick = $urandom_range(99, 0);
			if (pick < 15)
				repeat ($urandom_range(2, 1)) queue_char(blanks[$urandom_range(2, 0)]);
			else if (pick < 30)
				queue_char(marks[$urandom_range(7, 0)]);
			else if (pick < 50)
				queue_glyph();
			else if (pick < 82)
				queue_number();
			else if (pick < 94)
				queue_char(8'($urandom_range(255, 0)));
			else
				queue_end();
		end
	endfunction

	task automatic drain();
		while (text_chars.size() != 0 || char_valid || due_tokens.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin : drive_chars
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (!(char_valid && !char_taken)) begin
			if (text_chars.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				char_data <= text_chars.pop_front();
				char_valid <= 1'b1;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			tok_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 300;
			tok_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			tok_ready <= 1'b0;
		end else begin
			tok_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watch_tokens
		tok_item_t want;
		if (!arst_n) begin
			char_taken <= 1'b0;
		end else begin
			char_taken <= char_valid && char_ready;
			if (char_valid && char_ready)
				lex_char(char_data);
			if (tok_valid && tok_ready) begin
				if (due_tokens.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected token beat kind=%0d code=%h num=%h last=%b",
							$realtime, tok_data.token_kind, tok_data.code_value,
							tok_data.number_value, tok_data.last);
					mismatches++;
				end else begin
					want = due_tokens.pop_front();
					if (tok_data.token_kind !== want.token_kind
							|| tok_data.code_value !== want.code_value
							|| tok_data.number_value !== want.number_value
							|| tok_data.last !== want.last) begin
						if (mismatches < 10)
							$display("%0t: token mismatch exp kind=%0d code=%h num=%h last=%b %s",
								$realtime, want.token_kind, want.code_value,
								want.number_value, want.last,
								$sformatf("got kind=%0d code=%h num=%h last=%b",
									tok_data.token_kind, tok_data.code_value,
									tok_data.number_value, tok_data.last));
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		send_idle_pct = 19;
		recv_idle_pct = 78;
		foreach (directed_text[i])
			queue_char(directed_text[i]);
		queue_end();
		queue_char(CH_AT);
		queue_end();
		queue_random_text(240);
		drain();

		send_idle_pct = 78;
		recv_idle_pct = 19;
		queue_random_text(240);
		drain();

		// output held off while bytes keep coming, so the input backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_text(240);
		hold_req = ~hold_req;
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_tokens.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/gtt_pkg.sv
sv/gtt_ctrl.sv
sv/gtt_dp.sv
sv/glyph_text_tokenizer.sv
tb/tb.sv
